FILE: sv/oaht_pkg.sv
package oaht_pkg;

    // Default configuration of the table.
    localparam int ORDER_DEF       = 8;
    localparam int VALUE_WIDTH_DEF = 32;

    // Fixed widths of the request and response fields.
    localparam int KEY_W    = 32;
    localparam int OP_W     = 2;
    localparam int VALUE_IO_W = 32;

    // Fibonacci hashing multiplier, 2^32 divided by the golden ratio.
    localparam logic [KEY_W-1:0] FIB_MAGIC = 32'd2654435769;

    // Slot marks.
    localparam logic [1:0] MARK_EMPTY   = 2'd0;
    localparam logic [1:0] MARK_FULL    = 2'd1;
    localparam logic [1:0] MARK_DELETED = 2'd2;

    // Request opcodes. The unused code behaves as a get.
    localparam logic [OP_W-1:0] OP_GET    = 2'd0;
    localparam logic [OP_W-1:0] OP_PUT    = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    // Write strobes from the sequencer to the slot store.
    typedef struct packed {
        logic       mark_en;
        logic [1:0] mark;
        logic       data_en;
    } mem_wr_t;

endpackage

FILE: sv/oaht_hash.sv
module oaht_hash #(
    parameter int ORDER = oaht_pkg::ORDER_DEF
) (
    input  logic                       clk,
    input  logic                       load,
    input  logic [oaht_pkg::KEY_W-1:0] key,
    output logic [ORDER-1:0]           home
);
    import oaht_pkg::*;

    logic [KEY_W-1:0] prod_reg;
    logic [KEY_W-1:0] prod_next;

    // Only the low 32 bits of the product matter, so the multiplier is 32 by 32.
    assign prod_next = key * FIB_MAGIC;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= prod_next;
        end
    end

    assign home = prod_reg[KEY_W-1 -: ORDER];

endmodule

FILE: sv/oaht_store.sv
module oaht_store #(
    parameter int ORDER       = oaht_pkg::ORDER_DEF,
    parameter int VALUE_WIDTH = oaht_pkg::VALUE_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic [ORDER-1:0]           rd_addr,
    input  logic [ORDER-1:0]           wr_addr,
    input  oaht_pkg::mem_wr_t          wr,
    input  logic [oaht_pkg::KEY_W-1:0] wr_key,
    input  logic [VALUE_WIDTH-1:0]     wr_value,
    output logic [1:0]                 rd_mark,
    output logic [oaht_pkg::KEY_W-1:0] rd_key,
    output logic [VALUE_WIDTH-1:0]     rd_value
);
    import oaht_pkg::*;

    localparam int SLOTS  = 1 << ORDER;
    localparam int DATA_W = KEY_W + VALUE_WIDTH;

    logic [1:0]        mark_mem [SLOTS];
    logic [DATA_W-1:0] data_mem [SLOTS];
    logic [DATA_W-1:0] data_rd_reg;

    // Mark memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr.mark_en)
        begin
            mark_mem[wr_addr] <= wr.mark;
        end
        rd_mark <= mark_mem[rd_addr];
    end

    // Key and value share one memory word.
    always_ff @(posedge clk)
    begin
        if (wr.data_en)
        begin
            data_mem[wr_addr] <= {wr_key, wr_value};
        end
        data_rd_reg <= data_mem[rd_addr];
    end

    assign rd_key   = data_rd_reg[DATA_W-1 -: KEY_W];
    assign rd_value = data_rd_reg[VALUE_WIDTH-1:0];

endmodule

FILE: sv/oaht_ctrl.sv
module oaht_ctrl #(
    parameter int ORDER       = oaht_pkg::ORDER_DEF,
    parameter int VALUE_WIDTH = oaht_pkg::VALUE_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  logic [oaht_pkg::OP_W-1:0]       opcode,
    input  logic [oaht_pkg::KEY_W-1:0]      key,
    input  logic [oaht_pkg::VALUE_IO_W-1:0] new_value,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output logic                            hit,
    output logic [oaht_pkg::VALUE_IO_W-1:0] old_value,
    output logic                            status,
    output logic                            hash_load,
    input  logic [ORDER-1:0]                home,
    output logic [ORDER-1:0]                rd_addr,
    output logic [ORDER-1:0]                wr_addr,
    output oaht_pkg::mem_wr_t               wr,
    output logic [oaht_pkg::KEY_W-1:0]      wr_key,
    output logic [VALUE_WIDTH-1:0]          wr_value,
    input  logic [1:0]                      rd_mark,
    input  logic [oaht_pkg::KEY_W-1:0]      rd_key,
    input  logic [VALUE_WIDTH-1:0]          rd_value
);
    import oaht_pkg::*;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_HASH   = 3'd2;
    localparam logic [2:0] ST_PROBE  = 3'd3;
    localparam logic [2:0] ST_COMMIT = 3'd4;

    // Control state.
    logic [2:0]             state_reg,    state_next;
    logic [ORDER-1:0]       clr_addr_reg, clr_addr_next;
    logic                   rsp_valid_reg, rsp_valid_next;

    // Request and probe context.
    logic [OP_W-1:0]        op_reg,        op_next;
    logic [KEY_W-1:0]       key_reg,       key_next;
    logic [VALUE_WIDTH-1:0] val_reg,       val_next;
    logic [ORDER-1:0]       pos_reg,       pos_next;
    logic [ORDER-1:0]       cnt_reg,       cnt_next;
    logic                   seen_del_reg,  seen_del_next;
    logic [ORDER-1:0]       first_del_reg, first_del_next;
    logic                   hit_reg,       hit_next;
    logic                   free_reg,      free_next;
    logic [ORDER-1:0]       where_reg,     where_next;
    logic [VALUE_WIDTH-1:0] old_reg,       old_next;

    // Response payload.
    logic                   rsp_hit_reg,    rsp_hit_next;
    logic [VALUE_IO_W-1:0]  rsp_old_reg,    rsp_old_next;
    logic                   rsp_status_reg, rsp_status_next;

    logic                   accept;
    logic                   rsp_free;
    logic                   is_match;
    logic                   is_empty;
    logic                   is_del;
    logic                   seen_now;
    logic [ORDER-1:0]       first_now;
    logic [63:0]            nv_wide;
    logic [63:0]            old_wide;

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign hash_load = accept;
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;

    assign nv_wide  = 64'(new_value);
    assign old_wide = 64'(old_reg);

    assign is_match  = (rd_mark == MARK_FULL) && (rd_key == key_reg);
    assign is_empty  = (rd_mark == MARK_EMPTY);
    assign is_del    = (rd_mark == MARK_DELETED);
    assign seen_now  = seen_del_reg || is_del;
    assign first_now = seen_del_reg ? first_del_reg : pos_reg;

    assign wr_key   = key_reg;
    assign wr_value = val_reg;

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        op_next         = op_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        pos_next        = pos_reg;
        cnt_next        = cnt_reg;
        seen_del_next   = seen_del_reg;
        first_del_next  = first_del_reg;
        hit_next        = hit_reg;
        free_next       = free_reg;
        where_next      = where_reg;
        old_next        = old_reg;
        rsp_hit_next    = rsp_hit_reg;
        rsp_old_next    = rsp_old_reg;
        rsp_status_next = rsp_status_reg;
        rd_addr         = pos_reg;
        wr_addr         = where_reg;
        wr              = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                wr_addr       = clr_addr_reg;
                wr.mark_en    = 1'b1;
                wr.mark       = MARK_EMPTY;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (&clr_addr_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next    = opcode;
                    key_next   = key;
                    val_next   = nv_wide[VALUE_WIDTH-1:0];
                    state_next = ST_HASH;
                end
            end
            ST_HASH:
            begin
                rd_addr       = home;
                pos_next      = home;
                cnt_next      = '0;
                seen_del_next = 1'b0;
                state_next    = ST_PROBE;
            end
            ST_PROBE:
            begin
                // The next slot is read ahead; it is dropped if the walk stops here.
                rd_addr = pos_reg + 1'b1;
                if (is_match)
                begin
                    hit_next   = 1'b1;
                    free_next  = 1'b0;
                    where_next = pos_reg;
                    old_next   = rd_value;
                    state_next = ST_COMMIT;
                end
                else if (is_empty)
                begin
                    hit_next   = 1'b0;
                    free_next  = 1'b1;
                    where_next = first_now;
                    old_next   = '0;
                    state_next = ST_COMMIT;
                end
                else if (&cnt_reg)
                begin
                    // Every slot has been visited without a match or an empty slot.
                    hit_next   = 1'b0;
                    free_next  = seen_now;
                    where_next = first_now;
                    old_next   = '0;
                    state_next = ST_COMMIT;
                end
                else
                begin
                    seen_del_next  = seen_now;
                    first_del_next = first_now;
                    pos_next       = pos_reg + 1'b1;
                    cnt_next       = cnt_reg + 1'b1;
                end
            end
            ST_COMMIT:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_hit_next    = hit_reg;
                    rsp_old_next    = old_wide[VALUE_IO_W-1:0];
                    rsp_status_next = 1'b0;
                    state_next      = ST_IDLE;
                    if (op_reg == OP_PUT)
                    begin
                        if (hit_reg)
                        begin
                            wr.data_en = 1'b1;
                        end
                        else if (free_reg)
                        begin
                            wr.data_en = 1'b1;
                            wr.mark_en = 1'b1;
                            wr.mark    = MARK_FULL;
                        end
                        else
                        begin
                            rsp_status_next = 1'b1;
                        end
                    end
                    else if ((op_reg == OP_REMOVE) && hit_reg)
                    begin
                        wr.mark_en = 1'b1;
                        wr.mark    = MARK_DELETED;
                    end
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        pos_reg        <= pos_next;
        cnt_reg        <= cnt_next;
        seen_del_reg   <= seen_del_next;
        first_del_reg  <= first_del_next;
        hit_reg        <= hit_next;
        free_reg       <= free_next;
        where_reg      <= where_next;
        old_reg        <= old_next;
        rsp_hit_reg    <= rsp_hit_next;
        rsp_old_reg    <= rsp_old_next;
        rsp_status_reg <= rsp_status_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign hit       = rsp_hit_reg;
    assign old_value = rsp_old_reg;
    assign status    = rsp_status_reg;

`ifndef SYNTH
    // A new response is only ever produced by the commit step.
    a_rsp_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_COMMIT))
        else $error("response raised outside the commit step");

    // A full table never reports a hit or a value.
    a_full_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_status_reg) |-> (!rsp_hit_reg && (rsp_old_reg == '0)))
        else $error("table-full response carries a hit or a value");

    // The memories are written only by the clearing pass or the commit step.
    a_write_window: assert property (@(posedge clk) disable iff (!rst_n)
        (wr.mark_en || wr.data_en) |-> ((state_reg == ST_CLEAR) || (state_reg == ST_COMMIT)))
        else $error("slot store written outside clearing or commit");

    // An accepted request always starts with the hash step.
    a_accept_hash: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_HASH))
        else $error("accepted request did not enter the hash step");
`endif

endmodule

FILE: sv/open_address_hash_table_top.sv
// Channel    Direction  Handshake             Beat contents
// request    in         req_valid/req_stall   opcode, key, new_value
// response   out        rsp_valid/rsp_stall   hit, old_value, status
//
// A response is presented once its request has passed the hash step, the probe
// walk over P slots (1 to 2^ORDER) and the commit step; the probe walk reads one
// slot per cycle from the mark and data memories. The next request can be
// accepted once the commit step has returned the sequencer to idle, so the
// block takes no new request before it is through with the last one.
// After reset the block marks every slot empty and holds req_stall high
// meanwhile.
// A finished response waits in the output register while the next request is
// already being accepted; the commit step only waits if that register is still
// held by rsp_stall.
module open_address_hash_table_top #(
    parameter int ORDER       = oaht_pkg::ORDER_DEF,
    parameter int VALUE_WIDTH = oaht_pkg::VALUE_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  logic [oaht_pkg::OP_W-1:0]       opcode,
    input  logic [oaht_pkg::KEY_W-1:0]      key,
    input  logic [oaht_pkg::VALUE_IO_W-1:0] new_value,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output logic                            hit,
    output logic [oaht_pkg::VALUE_IO_W-1:0] old_value,
    output logic                            status
);
    import oaht_pkg::*;

    // Home slot of the key being accepted, registered after the multiplier.
    logic                   hash_load;
    logic [ORDER-1:0]       home;

    // Slot store access from the sequencer.
    logic [ORDER-1:0]       rd_addr;
    logic [ORDER-1:0]       wr_addr;
    mem_wr_t                wr;
    logic [KEY_W-1:0]       wr_key;
    logic [VALUE_WIDTH-1:0] wr_value;
    logic [1:0]             rd_mark;
    logic [KEY_W-1:0]       rd_key;
    logic [VALUE_WIDTH-1:0] rd_value;

    // The multiplier is loaded in the accepting cycle, so the home slot is
    // ready for the first memory read in the following cycle.
    oaht_hash #(
        .ORDER (ORDER)
    ) u_hash (
        .clk  (clk),
        .load (hash_load),
        .key  (key),
        .home (home)
    );

    // The sequencer clears the marks after reset, walks the probe sequence and
    // commits the single write of each request together with its response.
    // Reads and writes of one request never overlap, and the next request
    // cannot read before the commit write has landed, so no forwarding is needed.
    oaht_ctrl #(
        .ORDER       (ORDER),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .opcode    (opcode),
        .key       (key),
        .new_value (new_value),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .hit       (hit),
        .old_value (old_value),
        .status    (status),
        .hash_load (hash_load),
        .home      (home),
        .rd_addr   (rd_addr),
        .wr_addr   (wr_addr),
        .wr        (wr),
        .wr_key    (wr_key),
        .wr_value  (wr_value),
        .rd_mark   (rd_mark),
        .rd_key    (rd_key),
        .rd_value  (rd_value)
    );

    // Slot marks live in one memory; keys and values share a second one.
    oaht_store #(
        .ORDER       (ORDER),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_store (
        .clk      (clk),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr),
        .wr       (wr),
        .wr_key   (wr_key),
        .wr_value (wr_value),
        .rd_mark  (rd_mark),
        .rd_key   (rd_key),
        .rd_value (rd_value)
    );

endmodule

FILE: sim/tb_open_address_hash_table_top.sv
typedef logic [oaht_pkg::ORDER_DEF-1:0] slot_index_t;

typedef struct packed {
    logic                            hit;
    logic [oaht_pkg::VALUE_IO_W-1:0] old_value;
    logic                            status;
} table_reply_t;

// Shadow copy of the slot store. It applies each accepted request in order and
// keeps the reply that the block should give for it.
class hash_table_shadow;
    bit [oaht_pkg::KEY_W-1:0]      slot_keys   [1 << oaht_pkg::ORDER_DEF];
    bit [oaht_pkg::VALUE_IO_W-1:0] slot_values [1 << oaht_pkg::ORDER_DEF];
    bit [1:0]                      slot_marks  [1 << oaht_pkg::ORDER_DEF];
    table_reply_t                  awaited_replies [$];
    int                            errors;

    function slot_index_t home_slot(input logic [oaht_pkg::KEY_W-1:0] k);
        logic [oaht_pkg::KEY_W-1:0] prod;
        prod = k * oaht_pkg::FIB_MAGIC;
        return prod[oaht_pkg::KEY_W-1 -: oaht_pkg::ORDER_DEF];
    endfunction

    function void note_request(input logic [oaht_pkg::OP_W-1:0] op,
                               input logic [oaht_pkg::KEY_W-1:0] k,
                               input logic [oaht_pkg::VALUE_IO_W-1:0] v);
        slot_index_t                   pos;
        slot_index_t                   where;
        slot_index_t                   first_deleted;
        bit                            seen_deleted;
        bit                            found;
        bit                            have_free;
        bit                            done;
        int                            n;
        logic [oaht_pkg::VALUE_IO_W-1:0] stored;
        table_reply_t                  reply;

        stored = v & ((oaht_pkg::VALUE_WIDTH_DEF >= 32) ? 32'hFFFF_FFFF
                      : ((32'd1 << oaht_pkg::VALUE_WIDTH_DEF) - 32'd1));
        pos = home_slot(k);
        where = '0;
        first_deleted = '0;
        seen_deleted = 1'b0;
        found = 1'b0;
        have_free = 1'b0;
        done = 1'b0;
        for (n = 0; n < (1 << oaht_pkg::ORDER_DEF) && !done; n++)
        begin
            if (slot_marks[pos] == oaht_pkg::MARK_FULL && slot_keys[pos] == k)
            begin
                found = 1'b1;
                where = pos;
                done = 1'b1;
            end
            else if (slot_marks[pos] == oaht_pkg::MARK_EMPTY)
            begin
                where = seen_deleted ? first_deleted : pos;
                have_free = 1'b1;
                done = 1'b1;
            end
            else
            begin
                if (slot_marks[pos] == oaht_pkg::MARK_DELETED && !seen_deleted)
                begin
                    seen_deleted = 1'b1;
                    first_deleted = pos;
                end
                pos = pos + 1'b1;
            end
        end
        // A walk over every slot without an empty one falls back on the
        // first deleted slot, if any was passed.
        if (!done)
        begin
            where = first_deleted;
            have_free = seen_deleted;
        end

        reply.hit = found;
        reply.old_value = found ? slot_values[where] : '0;
        reply.status = 1'b0;
        if (op == oaht_pkg::OP_PUT)
        begin
            if (found)
                slot_values[where] = stored;
            else if (have_free)
            begin
                slot_keys[where] = k;
                slot_values[where] = stored;
                slot_marks[where] = oaht_pkg::MARK_FULL;
            end
            else
                reply.status = 1'b1;
        end
        else if (op == oaht_pkg::OP_REMOVE && found)
            slot_marks[where] = oaht_pkg::MARK_DELETED;
        awaited_replies.push_back(reply);
    endfunction

    function void check_response(input logic h,
                                 input logic [oaht_pkg::VALUE_IO_W-1:0] ov,
                                 input logic st);
        table_reply_t want;
        if (awaited_replies.size() == 0)
        begin
            $error("response beat with no request outstanding: hit %0b old_value %h status %0b",
                   h, ov, st);
            errors++;
        end
        else
        begin
            want = awaited_replies.pop_front();
            if (h !== want.hit)
            begin
                $error("hit: expected %0b, got %0b", want.hit, h);
                errors++;
            end
            if (ov !== want.old_value)
            begin
                $error("old_value: expected %h, got %h", want.old_value, ov);
                errors++;
            end
            if (st !== want.status)
            begin
                $error("status: expected %0b, got %0b", want.status, st);
                errors++;
            end
        end
    endfunction

    function int outstanding();
        return awaited_replies.size();
    endfunction
endclass

module tb_open_address_hash_table_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 1 << oaht_pkg::ORDER_DEF;
    // The fourth opcode has no name in the package; the block treats it as a get.
    localparam logic [oaht_pkg::OP_W-1:0] OP_SPARE = 2'd3;
    localparam int RESET_CYCLES = 8;
    // A request can walk every slot, so the settling time after the last
    // response covers one full probe walk and the output register.
    localparam int DRAIN_CYCLES = SLOTS + 16;
    // The timeout is set well above the slowest correct run, even with
    // every miss walking the whole table.
    localparam longint TIMEOUT_NS = 20_000_000;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            req_valid = 1'b0;
    logic                            req_stall;
    logic [oaht_pkg::OP_W-1:0]       opcode = oaht_pkg::OP_GET;
    logic [oaht_pkg::KEY_W-1:0]      key = '0;
    logic [oaht_pkg::VALUE_IO_W-1:0] new_value = '0;
    logic                            rsp_valid;
    logic                            rsp_stall = 1'b0;
    logic                            hit;
    logic [oaht_pkg::VALUE_IO_W-1:0] old_value;
    logic                            status;

    idle_mode_t                      idle_mode = IDLE_NONE;
    hash_table_shadow                book;
    // Keys that the random phases draw from, so that gets, puts and removes
    // keep meeting keys that are already stored.
    logic [oaht_pkg::KEY_W-1:0]      key_pool [$];

    open_address_hash_table_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .opcode    (opcode),
        .key       (key),
        .new_value (new_value),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .hit       (hit),
        .old_value (old_value),
        .status    (status)
    );

    always #5 clk = ~clk;

    // The response side stalls at random according to the current idling
    // phase. It changes only at the falling edge so that the block sees a
    // settled value at the rising edge.
    always @(negedge clk)
    begin
        rsp_stall <= (idle_mode == IDLE_RECEIVER && $urandom_range(99) < 67)
                  || (idle_mode == IDLE_BOTH && $urandom_range(99) < 10);
    end

    // A response beat is taken at a rising edge with valid high and stall low.
    // Sampling straight after the edge sees the values from before it.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            book.check_response(hit, old_value, status);
    end

    // Drives one request beat. It is entered at a falling edge and returns at
    // a falling edge, so valid is assigned once per time step: either lowered
    // for a gap or raised with the new payload, never both.
    task automatic send_request(input logic [oaht_pkg::OP_W-1:0] op,
                                input logic [oaht_pkg::KEY_W-1:0] k,
                                input logic [oaht_pkg::VALUE_IO_W-1:0] v);
        while ((idle_mode == IDLE_SENDER && $urandom_range(99) < 67)
            || (idle_mode == IDLE_BOTH && $urandom_range(99) < 10))
        begin
            req_valid <= 1'b0;
            @(posedge clk);
            @(negedge clk);
        end
        req_valid <= 1'b1;
        opcode <= op;
        key <= k;
        new_value <= v;
        // The payload stays put until the block takes it. During the clearing
        // pass after reset the block holds stall high, which this also covers.
        do
            @(posedge clk);
        while (req_stall);
        book.note_request(op, k, v);
        @(negedge clk);
    endtask

    // Draws random keys until one lands on the wanted home slot. About one
    // draw in SLOTS succeeds, so this is quick.
    function automatic logic [oaht_pkg::KEY_W-1:0] key_with_home(input slot_index_t h);
        logic [oaht_pkg::KEY_W-1:0] k;
        do
            k = $urandom();
        while (book.home_slot(k) != h);
        return k;
    endfunction

    // A stretch of random requests. Most keys come from the pool; the share
    // given by noise_pct is fresh random keys, which nearly always miss. The
    // idling phase moves on every fifty beats, so each phase falls on every
    // state of the table.
    task automatic run_mix(input int items, input int put_pct, input int remove_pct,
                           input int spare_pct, input int noise_pct);
        logic [oaht_pkg::OP_W-1:0]       op;
        logic [oaht_pkg::KEY_W-1:0]      k;
        logic [oaht_pkg::VALUE_IO_W-1:0] v;
        int                              roll;
        int                              i;
        for (i = 0; i < items; i++)
        begin
            idle_mode = idle_mode_t'((i / 50) % 4);
            roll = $urandom_range(99);
            if (roll < put_pct)
                op = oaht_pkg::OP_PUT;
            else if (roll < put_pct + remove_pct)
                op = oaht_pkg::OP_REMOVE;
            else if (roll < put_pct + remove_pct + spare_pct)
                op = OP_SPARE;
            else
                op = oaht_pkg::OP_GET;
            if (key_pool.size() == 0 || $urandom_range(99) < noise_pct)
                k = $urandom();
            else
                k = key_pool[$urandom_range(key_pool.size() - 1)];
            roll = $urandom_range(7);
            if (roll == 0)
                v = '0;
            else if (roll == 1)
                v = '1;
            else
                v = $urandom();
            send_request(op, k, v);
        end
    endtask

    initial
    begin
        logic [oaht_pkg::KEY_W-1:0] wrap_a;
        logic [oaht_pkg::KEY_W-1:0] wrap_b;
        logic [oaht_pkg::KEY_W-1:0] wrap_c;
        logic [oaht_pkg::KEY_W-1:0] wrap_d;
        logic [oaht_pkg::KEY_W-1:0] lone_key;
        slot_index_t                chain_homes [3];
        int                         n;

        book = new;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. Four keys that share the last slot as their home, so
        // their probe chain wraps round to slot 0 and beyond.
        wrap_a = key_with_home(slot_index_t'(SLOTS - 1));
        wrap_b = key_with_home(slot_index_t'(SLOTS - 1));
        wrap_c = key_with_home(slot_index_t'(SLOTS - 1));
        wrap_d = key_with_home(slot_index_t'(SLOTS - 1));
        lone_key = $urandom();

        // Misses on an empty table, including a remove of an absent key.
        send_request(oaht_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000);
        send_request(oaht_pkg::OP_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // Extreme keys and values; the second put of key zero replaces.
        send_request(oaht_pkg::OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(oaht_pkg::OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(oaht_pkg::OP_GET, 32'h0000_0000, 32'h5555_5555);
        send_request(oaht_pkg::OP_PUT, 32'h0000_0000, 32'hAAAA_AAAA);
        // The spare opcode reads like a get and must leave the table alone.
        send_request(OP_SPARE, 32'hFFFF_FFFF, 32'h1234_5678);
        send_request(OP_SPARE, lone_key, 32'h8000_0001);
        send_request(oaht_pkg::OP_GET, lone_key, 32'h0000_0000);
        // Build a wrapping chain, punch a hole in it, then check that lookups
        // walk past the deleted slot and that a new key reuses it.
        send_request(oaht_pkg::OP_PUT, wrap_a, 32'h0000_0001);
        send_request(oaht_pkg::OP_PUT, wrap_b, 32'h8000_0000);
        send_request(oaht_pkg::OP_PUT, wrap_c, 32'h7FFF_FFFF);
        send_request(oaht_pkg::OP_REMOVE, wrap_b, 32'h0000_0000);
        send_request(oaht_pkg::OP_GET, wrap_c, 32'h0000_0000);
        send_request(oaht_pkg::OP_PUT, wrap_d, 32'hFEDC_BA98);
        send_request(oaht_pkg::OP_GET, wrap_d, 32'h0000_0000);
        send_request(oaht_pkg::OP_REMOVE, wrap_b, 32'h0000_0000);
        send_request(oaht_pkg::OP_PUT, wrap_c, 32'hFFFF_FFFF);
        send_request(oaht_pkg::OP_REMOVE, wrap_a, 32'h0000_0000);
        send_request(oaht_pkg::OP_GET, wrap_a, 32'h0000_0000);
        send_request(oaht_pkg::OP_GET, wrap_c, 32'h0000_0000);
        send_request(oaht_pkg::OP_PUT, lone_key, $urandom());
        send_request(oaht_pkg::OP_REMOVE, lone_key, $urandom());

        // Light load: a dozen keys churned through every operation.
        key_pool.delete();
        repeat (12) key_pool.push_back($urandom());
        run_mix(400, 40, 25, 5, 5);

        // Long probe chains: all keys share one of three homes, one of them
        // the last slot, so walks cross deleted slots and wrap round.
        chain_homes[0] = slot_index_t'(SLOTS - 1);
        chain_homes[1] = '0;
        chain_homes[2] = slot_index_t'(SLOTS / 2);
        key_pool.delete();
        for (n = 0; n < 24; n++)
            key_pool.push_back(key_with_home(chain_homes[n % 3]));
        run_mix(300, 35, 30, 5, 5);

        // Moderate load spread over the whole table.
        key_pool.delete();
        repeat (80) key_pool.push_back($urandom());
        run_mix(230, 45, 20, 5, 5);

        // Fill the table with fresh keys. Once every slot is taken, puts of
        // absent keys must report the table full and store nothing.
        run_mix(300, 90, 0, 2, 100);

        // Churn on a full table: the pool is the keys now stored. Removes open
        // deleted slots, which later puts must find without any empty slot.
        key_pool.delete();
        for (n = 0; n < SLOTS; n++)
        begin
            if (book.slot_marks[n] == oaht_pkg::MARK_FULL)
                key_pool.push_back(book.slot_keys[n]);
        end
        run_mix(200, 35, 35, 5, 10);

        // All requests are in. Let every response drain, then give the block
        // time to show any stray beat.
        req_valid <= 1'b0;
        idle_mode = IDLE_NONE;
        while (book.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (book.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Guard against a hang, for example a request or response that is never
    // taken.
    initial
    begin
        #(TIMEOUT_NS);
        $display("end of test: mismatches");
        $finish;
    end
endmodule
